>>> sv/dsf_pkg.sv
// shared types, opcodes and micro-op codes of the dual-stack processor core
`timescale 1ns / 1ps

package dsf_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mem_addr;
    logic [7:0]  mem_byte;
    logic [7:0]  in_char;
  } in_word_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_char;
    logic        halted;
    logic [15:0] top_value;
    logic [7:0]  read_byte;
    logic [15:0] pc_value;
  } out_word_t;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [4:0] OP_HALT  = 5'd0;
  localparam logic [4:0] OP_ADD   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_MUL   = 5'd3;
  localparam logic [4:0] OP_DIV   = 5'd4;
  localparam logic [4:0] OP_NOT   = 5'd5;
  localparam logic [4:0] OP_AND   = 5'd6;
  localparam logic [4:0] OP_OR    = 5'd7;
  localparam logic [4:0] OP_XOR   = 5'd8;
  localparam logic [4:0] OP_SHL   = 5'd9;
  localparam logic [4:0] OP_SHR   = 5'd10;
  localparam logic [4:0] OP_IN    = 5'd11;
  localparam logic [4:0] OP_OUT   = 5'd12;
  localparam logic [4:0] OP_READ  = 5'd13;
  localparam logic [4:0] OP_WRITE = 5'd14;
  localparam logic [4:0] OP_LD16  = 5'd15;
  localparam logic [4:0] OP_LD8   = 5'd16;
  localparam logic [4:0] OP_ST16  = 5'd17;
  localparam logic [4:0] OP_ST8   = 5'd18;
  localparam logic [4:0] OP_LIT16 = 5'd19;
  localparam logic [4:0] OP_LIT8  = 5'd20;
  localparam logic [4:0] OP_ZJUMP = 5'd21;
  localparam logic [4:0] OP_NEXT  = 5'd22;
  localparam logic [4:0] OP_DROP  = 5'd23;
  localparam logic [4:0] OP_DUP   = 5'd24;
  localparam logic [4:0] OP_OVER  = 5'd25;
  localparam logic [4:0] OP_SWAP  = 5'd26;
  localparam logic [4:0] OP_PUSH  = 5'd27;
  localparam logic [4:0] OP_POP   = 5'd28;
  localparam logic [4:0] OP_PEEK  = 5'd29;
  localparam logic [4:0] OP_RET   = 5'd30;
  localparam logic [4:0] OP_NOP   = 5'd31;

  localparam logic [4:0] UOP_NONE   = 5'd0;
  localparam logic [4:0] UOP_ACCEPT = 5'd1;
  localparam logic [4:0] UOP_MEM    = 5'd2;
  localparam logic [4:0] UOP_RDCAP  = 5'd3;
  localparam logic [4:0] UOP_F0     = 5'd4;
  localparam logic [4:0] UOP_F1     = 5'd5;
  localparam logic [4:0] UOP_F2     = 5'd6;
  localparam logic [4:0] UOP_CALL   = 5'd7;
  localparam logic [4:0] UOP_LD     = 5'd8;
  localparam logic [4:0] UOP_LX     = 5'd9;
  localparam logic [4:0] UOP_DIV    = 5'd10;
  localparam logic [4:0] UOP_RA     = 5'd11;
  localparam logic [4:0] UOP_RB     = 5'd12;
  localparam logic [4:0] UOP_RC     = 5'd13;
  localparam logic [4:0] UOP_WA     = 5'd14;
  localparam logic [4:0] UOP_WB     = 5'd15;
  localparam logic [4:0] UOP_EX     = 5'd16;
  localparam logic [4:0] UOP_W1     = 5'd17;
  localparam logic [4:0] UOP_W2     = 5'd18;
  localparam logic [4:0] UOP_T0     = 5'd19;
  localparam logic [4:0] UOP_T1     = 5'd20;

  typedef struct packed {
    logic [4:0] uop;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       halted;
    logic       fetch_needed;
    logic       word_even;
    logic       op_rd;
    logic       op_wr;
    logic       op_two_wr;
    logic       op_div;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> sv/dsf_ctrl.sv
// sequencer that steps the datapath through fetch, operand load, execute and report
`timescale 1ns / 1ps

module dsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              busy,
  input  dsf_pkg::dp_stat_t stat,
  output dsf_pkg::ctl_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_MEM  = 5'd2;
  localparam logic [4:0] S_RDW  = 5'd3;
  localparam logic [4:0] S_F0   = 5'd4;
  localparam logic [4:0] S_F1   = 5'd5;
  localparam logic [4:0] S_F2   = 5'd6;
  localparam logic [4:0] S_CALL = 5'd7;
  localparam logic [4:0] S_LD   = 5'd8;
  localparam logic [4:0] S_LX   = 5'd9;
  localparam logic [4:0] S_DIV  = 5'd10;
  localparam logic [4:0] S_RA   = 5'd11;
  localparam logic [4:0] S_RB   = 5'd12;
  localparam logic [4:0] S_RC   = 5'd13;
  localparam logic [4:0] S_WA   = 5'd14;
  localparam logic [4:0] S_WB   = 5'd15;
  localparam logic [4:0] S_EX   = 5'd16;
  localparam logic [4:0] S_W1   = 5'd17;
  localparam logic [4:0] S_W2   = 5'd18;
  localparam logic [4:0] S_T0   = 5'd19;
  localparam logic [4:0] S_T1   = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.uop   = dsf_pkg::UOP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.uop   = dsf_pkg::UOP_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.cmd == dsf_pkg::CMD_WRITE || stat.cmd == dsf_pkg::CMD_READ) begin
          state_nxt = S_MEM;
        end else if (stat.cmd == dsf_pkg::CMD_STEP && !stat.halted) begin
          state_nxt = stat.fetch_needed ? S_F0 : S_LD;
        end else begin
          state_nxt = S_T0;
        end
      end
      S_MEM: begin
        cmd.uop   = dsf_pkg::UOP_MEM;
        state_nxt = (stat.cmd == dsf_pkg::CMD_READ) ? S_RDW : S_T0;
      end
      S_RDW: begin
        cmd.uop   = dsf_pkg::UOP_RDCAP;
        state_nxt = S_T0;
      end
      S_F0: begin
        cmd.uop   = dsf_pkg::UOP_F0;
        state_nxt = S_F1;
      end
      S_F1: begin
        cmd.uop   = dsf_pkg::UOP_F1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.uop   = dsf_pkg::UOP_F2;
        state_nxt = stat.word_even ? S_CALL : S_LD;
      end
      S_CALL: begin
        cmd.uop   = dsf_pkg::UOP_CALL;
        state_nxt = S_T0;
      end
      S_LD: begin
        cmd.uop   = dsf_pkg::UOP_LD;
        state_nxt = S_LX;
      end
      S_LX: begin
        cmd.uop = dsf_pkg::UOP_LX;
        cnt_nxt = '0;
        if (stat.op_div) begin
          state_nxt = S_DIV;
        end else if (stat.op_rd) begin
          state_nxt = S_RA;
        end else if (stat.op_wr) begin
          state_nxt = S_WA;
        end else begin
          state_nxt = S_EX;
        end
      end
      S_DIV: begin
        cmd.uop = dsf_pkg::UOP_DIV;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_EX;
        end
      end
      S_RA: begin
        cmd.uop   = dsf_pkg::UOP_RA;
        state_nxt = S_RB;
      end
      S_RB: begin
        cmd.uop   = dsf_pkg::UOP_RB;
        state_nxt = S_RC;
      end
      S_RC: begin
        cmd.uop   = dsf_pkg::UOP_RC;
        state_nxt = S_EX;
      end
      S_WA: begin
        cmd.uop   = dsf_pkg::UOP_WA;
        state_nxt = stat.op_two_wr ? S_WB : S_EX;
      end
      S_WB: begin
        cmd.uop   = dsf_pkg::UOP_WB;
        state_nxt = S_EX;
      end
      S_EX: begin
        cmd.uop   = dsf_pkg::UOP_EX;
        state_nxt = S_W1;
      end
      S_W1: begin
        cmd.uop   = dsf_pkg::UOP_W1;
        state_nxt = S_W2;
      end
      S_W2: begin
        cmd.uop   = dsf_pkg::UOP_W2;
        state_nxt = S_T0;
      end
      S_T0: begin
        cmd.uop   = dsf_pkg::UOP_T0;
        state_nxt = S_T1;
      end
      S_T1: begin
        if (stat.out_free) begin
          cmd.uop   = dsf_pkg::UOP_T1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> sv/dsf_dpath.sv
// datapath: byte memory, both stacks, core registers, divider and result register
`timescale 1ns / 1ps

module dsf_dpath #(
  parameter int MEM_BYTES   = 65536,
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dsf_pkg::ctl_cmd_t  cmd,
  output dsf_pkg::dp_stat_t  stat,
  input  dsf_pkg::in_word_t  in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output dsf_pkg::out_word_t out_data
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int PW = $clog2(STACK_DEPTH);
  localparam logic [PW-1:0] PTR_TOP = PW'(STACK_DEPTH - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_TOP) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PTR_TOP : p - 1'b1;
  endfunction

  logic [7:0]  mem [MEM_BYTES];
  logic [15:0] ds  [STACK_DEPTH];
  logic [15:0] rs  [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] ds_vld_r, rs_vld_r;

  logic [7:0]  mem_rdata_r;
  logic [15:0] ds_rd0_r, ds_rd1_r, rs_rd_r;

  dsf_pkg::in_word_t in_r;
  logic [15:0] pc_r, pend_r, word_r;
  logic [PW-1:0] dp_r, rp_r;
  logic [1:0]  slot_r;
  logic        halt_r;
  logic [7:0]  lo_r, m0_r, m1_r;
  logic [15:0] x_r, y_r, rt_r;
  logic [15:0] div_q_r, div_rem_r;
  logic        res_ov_r;
  logic [7:0]  res_oc_r, res_rb_r;
  logic        out_vld_r;
  dsf_pkg::out_word_t out_r;

  logic          wb1_en_r, wb2_en_r, rwb_en_r;
  logic [PW-1:0] wb1_a_r, wb2_a_r, rwb_a_r, wb_dp_r, wb_rp_r;
  logic [15:0]   wb1_d_r, wb2_d_r, rwb_d_r, wb_pc_r;
  logic [1:0]    wb_slot_r;
  logic          wb_halt_r, wb_ov_r;
  logic [7:0]    wb_oc_r;

  logic [4:0]    op;
  logic [PW-1:0] dp_p, dp_m, rp_p, rp_m;
  logic [15:0]   word_w, mem_base, bsx, alu_r;
  logic [31:0]   prod;
  logic [16:0]   rem_s;
  logic [17:0]   rem_diff;

  logic          mem_we, mem_re;
  logic [15:0]   mem_a;
  logic [7:0]    mem_wd;

  logic          ex_w1, ex_w2, ex_rw, ex_abandon, ex_halt, ex_ov;
  logic [PW-1:0] ex_w1a, ex_w2a, ex_rwa, ex_dp, ex_rp;
  logic [15:0]   ex_w1d, ex_w2d, ex_rwd, ex_pc;
  logic [7:0]    ex_oc;

  always_comb begin
    unique case (slot_r)
      2'd0:    op = pend_r[15:11];
      2'd1:    op = pend_r[10:6];
      default: op = pend_r[5:1];
    endcase
  end

  assign dp_p     = ptr_inc(dp_r);
  assign dp_m     = ptr_dec(dp_r);
  assign rp_p     = ptr_inc(rp_r);
  assign rp_m     = ptr_dec(rp_r);
  assign word_w   = {mem_rdata_r, lo_r};
  assign mem_base = (op == dsf_pkg::OP_LD16 || op == dsf_pkg::OP_LD8) ? x_r : pc_r;
  assign bsx      = {{8{m0_r[7]}}, m0_r};
  assign prod     = y_r * x_r;
  assign rem_s    = {div_rem_r, div_q_r[15]};
  assign rem_diff = {1'b0, rem_s} - {2'b00, x_r};

  assign stat.cmd          = in_r.cmd;
  assign stat.halted       = halt_r;
  assign stat.fetch_needed = (slot_r == 2'd3);
  assign stat.word_even    = ~lo_r[0];
  assign stat.op_rd        = (op == dsf_pkg::OP_LD16) || (op == dsf_pkg::OP_LD8) ||
                             (op == dsf_pkg::OP_LIT16) || (op == dsf_pkg::OP_LIT8) ||
                             (op == dsf_pkg::OP_ZJUMP) || (op == dsf_pkg::OP_NEXT);
  assign stat.op_wr        = (op == dsf_pkg::OP_ST16) || (op == dsf_pkg::OP_ST8);
  assign stat.op_two_wr    = (op == dsf_pkg::OP_ST16);
  assign stat.op_div       = (op == dsf_pkg::OP_DIV);
  assign stat.out_free     = !out_vld_r || !out_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // byte memory port
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_a  = pc_r;
    mem_wd = x_r[7:0];
    unique case (cmd.uop)
      dsf_pkg::UOP_MEM: begin
        mem_a  = in_r.mem_addr;
        mem_wd = in_r.mem_byte;
        mem_we = (in_r.cmd == dsf_pkg::CMD_WRITE);
        mem_re = (in_r.cmd == dsf_pkg::CMD_READ);
      end
      dsf_pkg::UOP_F0: mem_re = 1'b1;
      dsf_pkg::UOP_F1: begin
        mem_re = 1'b1;
        mem_a  = pc_r + 16'd1;
      end
      dsf_pkg::UOP_RA: begin
        mem_re = 1'b1;
        mem_a  = mem_base;
      end
      dsf_pkg::UOP_RB: begin
        mem_re = 1'b1;
        mem_a  = mem_base + 16'd1;
      end
      dsf_pkg::UOP_WA: begin
        mem_we = 1'b1;
        mem_a  = y_r;
      end
      dsf_pkg::UOP_WB: begin
        mem_we = 1'b1;
        mem_a  = y_r + 16'd1;
        mem_wd = x_r[15:8];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_a[AW-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_a[AW-1:0]];
    end
  end

  // execute one opcode from the loaded operands
  always_comb begin
    ex_w1      = 1'b0;
    ex_w1a     = dp_p;
    ex_w1d     = 16'd0;
    ex_w2      = 1'b0;
    ex_w2a     = dp_r;
    ex_w2d     = 16'd0;
    ex_rw      = 1'b0;
    ex_rwa     = rp_r;
    ex_rwd     = 16'd0;
    ex_dp      = dp_r;
    ex_rp      = rp_r;
    ex_pc      = pc_r;
    ex_abandon = 1'b0;
    ex_halt    = halt_r;
    ex_ov      = res_ov_r;
    ex_oc      = res_oc_r;
    case (op)
      dsf_pkg::OP_ADD: alu_r = y_r + x_r;
      dsf_pkg::OP_SUB: alu_r = y_r - x_r;
      dsf_pkg::OP_MUL: alu_r = prod[15:0];
      dsf_pkg::OP_DIV: alu_r = div_q_r;
      dsf_pkg::OP_AND: alu_r = y_r & x_r;
      dsf_pkg::OP_OR:  alu_r = y_r | x_r;
      dsf_pkg::OP_XOR: alu_r = y_r ^ x_r;
      dsf_pkg::OP_SHL: alu_r = (x_r < 16'd16) ? (y_r << x_r[3:0]) : 16'd0;
      dsf_pkg::OP_SHR: alu_r = (x_r < 16'd16) ? (y_r >> x_r[3:0]) : 16'd0;
      default:         alu_r = 16'd0;
    endcase
    case (op) inside
      dsf_pkg::OP_ADD, dsf_pkg::OP_SUB, dsf_pkg::OP_MUL, dsf_pkg::OP_DIV,
      dsf_pkg::OP_AND, dsf_pkg::OP_OR, dsf_pkg::OP_XOR, dsf_pkg::OP_SHL,
      dsf_pkg::OP_SHR: begin
        ex_w1  = 1'b1;
        ex_w1a = dp_m;
        ex_w1d = alu_r;
        ex_w2  = 1'b1;
        ex_w2a = dp_r;
        ex_dp  = dp_m;
      end
      dsf_pkg::OP_NOT: begin
        ex_w1  = 1'b1;
        ex_w1a = dp_r;
        ex_w1d = ~x_r;
      end
      dsf_pkg::OP_HALT: begin
        ex_halt    = 1'b1;
        ex_abandon = 1'b1;
      end
      dsf_pkg::OP_IN: begin
        ex_w1  = 1'b1;
        ex_w1d = {8'h00, in_r.in_char};
        ex_dp  = dp_p;
      end
      dsf_pkg::OP_OUT: begin
        ex_ov = 1'b1;
        ex_oc = x_r[7:0];
        ex_dp = dp_m;
      end
      dsf_pkg::OP_READ, dsf_pkg::OP_WRITE: ex_dp = ptr_dec(ptr_dec(dp_m));
      dsf_pkg::OP_LD16: begin
        ex_w1  = 1'b1;
        ex_w1d = {m1_r, m0_r};
        ex_w2  = 1'b1;
        ex_w2d = x_r + 16'd2;
        ex_dp  = dp_p;
      end
      dsf_pkg::OP_LD8: begin
        ex_w1  = 1'b1;
        ex_w1d = {8'h00, m0_r};
        ex_w2  = 1'b1;
        ex_w2d = x_r + 16'd1;
        ex_dp  = dp_p;
      end
      dsf_pkg::OP_ST16: begin
        ex_w1  = 1'b1;
        ex_w1a = dp_m;
        ex_w1d = y_r + 16'd2;
        ex_dp  = dp_m;
      end
      dsf_pkg::OP_ST8: begin
        ex_w1  = 1'b1;
        ex_w1a = dp_m;
        ex_w1d = y_r + 16'd1;
        ex_dp  = dp_m;
      end
      dsf_pkg::OP_LIT16: begin
        ex_w1  = 1'b1;
        ex_w1d = {m1_r, m0_r};
        ex_dp  = dp_p;
        ex_pc  = pc_r + 16'd2;
      end
      dsf_pkg::OP_LIT8: begin
        ex_w1  = 1'b1;
        ex_w1d = bsx;
        ex_dp  = dp_p;
        ex_pc  = pc_r + 16'd1;
      end
      dsf_pkg::OP_ZJUMP: begin
        ex_dp = dp_m;
        if (x_r == 16'd0) begin
          ex_pc      = pc_r + bsx;
          ex_abandon = 1'b1;
        end else begin
          ex_pc = pc_r + 16'd1;
        end
      end
      dsf_pkg::OP_NEXT: begin
        if (rt_r != 16'd0) begin
          ex_rw      = 1'b1;
          ex_rwa     = rp_r;
          ex_rwd     = rt_r - 16'd1;
          ex_pc      = pc_r - {8'h00, m0_r};
          ex_abandon = 1'b1;
        end else begin
          ex_rp = rp_m;
          ex_pc = pc_r + 16'd1;
        end
      end
      dsf_pkg::OP_DROP: ex_dp = dp_m;
      dsf_pkg::OP_DUP: begin
        ex_w1  = 1'b1;
        ex_w1d = x_r;
        ex_dp  = dp_p;
      end
      dsf_pkg::OP_OVER: begin
        ex_w1  = 1'b1;
        ex_w1d = y_r;
        ex_dp  = dp_p;
      end
      dsf_pkg::OP_SWAP: begin
        ex_w1  = 1'b1;
        ex_w1a = dp_r;
        ex_w1d = y_r;
        ex_w2  = 1'b1;
        ex_w2a = dp_m;
        ex_w2d = x_r;
      end
      dsf_pkg::OP_PUSH: begin
        ex_rw  = 1'b1;
        ex_rwa = rp_p;
        ex_rwd = x_r;
        ex_rp  = rp_p;
        ex_dp  = dp_m;
      end
      dsf_pkg::OP_POP: begin
        ex_w1  = 1'b1;
        ex_w1d = rt_r;
        ex_dp  = dp_p;
        ex_rp  = rp_m;
      end
      dsf_pkg::OP_PEEK: begin
        ex_w1  = 1'b1;
        ex_w1d = rt_r;
        ex_dp  = dp_p;
      end
      dsf_pkg::OP_RET: begin
        ex_pc      = rt_r;
        ex_rp      = rp_m;
        ex_abandon = 1'b1;
      end
      default: ;
    endcase
  end

  // stacks, with a valid bit per entry so unwritten cells read zero
  always_ff @(posedge clk) begin
    if (cmd.uop == dsf_pkg::UOP_W1 && wb1_en_r) begin
      ds[wb1_a_r] <= wb1_d_r;
    end else if (cmd.uop == dsf_pkg::UOP_W2 && wb2_en_r) begin
      ds[wb2_a_r] <= wb2_d_r;
    end
    if (cmd.uop == dsf_pkg::UOP_CALL) begin
      rs[rp_p] <= pc_r;
    end else if (cmd.uop == dsf_pkg::UOP_W1 && rwb_en_r) begin
      rs[rwb_a_r] <= rwb_d_r;
    end
    if (cmd.uop == dsf_pkg::UOP_LD) begin
      ds_rd0_r <= ds_vld_r[dp_r] ? ds[dp_r] : 16'd0;
      ds_rd1_r <= ds_vld_r[dp_m] ? ds[dp_m] : 16'd0;
      rs_rd_r  <= rs_vld_r[rp_r] ? rs[rp_r] : 16'd0;
    end else if (cmd.uop == dsf_pkg::UOP_T0) begin
      ds_rd0_r <= ds_vld_r[dp_r] ? ds[dp_r] : 16'd0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= 16'd0;
      dp_r      <= PTR_TOP;
      rp_r      <= PTR_TOP;
      pend_r    <= 16'd0;
      slot_r    <= 2'd3;
      halt_r    <= 1'b0;
      ds_vld_r  <= '0;
      rs_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      unique case (cmd.uop)
        dsf_pkg::UOP_F2: begin
          pc_r <= pc_r + 16'd2;
          if (word_w[0]) begin
            pend_r <= word_w;
            slot_r <= 2'd0;
          end
        end
        dsf_pkg::UOP_CALL: begin
          rp_r           <= rp_p;
          pc_r           <= word_r;
          rs_vld_r[rp_p] <= 1'b1;
        end
        dsf_pkg::UOP_W1: begin
          dp_r   <= wb_dp_r;
          rp_r   <= wb_rp_r;
          pc_r   <= wb_pc_r;
          slot_r <= wb_slot_r;
          halt_r <= wb_halt_r;
          if (wb1_en_r) begin
            ds_vld_r[wb1_a_r] <= 1'b1;
          end
          if (rwb_en_r) begin
            rs_vld_r[rwb_a_r] <= 1'b1;
          end
        end
        dsf_pkg::UOP_W2: begin
          if (wb2_en_r) begin
            ds_vld_r[wb2_a_r] <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cmd.uop == dsf_pkg::UOP_T1) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.uop)
      dsf_pkg::UOP_ACCEPT: begin
        in_r     <= in_data;
        res_ov_r <= 1'b0;
        res_oc_r <= 8'd0;
        res_rb_r <= 8'd0;
      end
      dsf_pkg::UOP_RDCAP: res_rb_r <= mem_rdata_r;
      dsf_pkg::UOP_F1:    lo_r <= mem_rdata_r;
      dsf_pkg::UOP_F2:    word_r <= word_w;
      dsf_pkg::UOP_LX: begin
        x_r       <= ds_rd0_r;
        y_r       <= ds_rd1_r;
        rt_r      <= rs_rd_r;
        div_q_r   <= ds_rd1_r;
        div_rem_r <= 16'd0;
      end
      dsf_pkg::UOP_DIV: begin
        if (!rem_diff[17]) begin
          div_rem_r <= rem_diff[15:0];
          div_q_r   <= {div_q_r[14:0], 1'b1};
        end else begin
          div_rem_r <= rem_s[15:0];
          div_q_r   <= {div_q_r[14:0], 1'b0};
        end
      end
      dsf_pkg::UOP_RB: m0_r <= mem_rdata_r;
      dsf_pkg::UOP_RC: m1_r <= mem_rdata_r;
      dsf_pkg::UOP_EX: begin
        wb1_en_r  <= ex_w1;
        wb1_a_r   <= ex_w1a;
        wb1_d_r   <= ex_w1d;
        wb2_en_r  <= ex_w2;
        wb2_a_r   <= ex_w2a;
        wb2_d_r   <= ex_w2d;
        rwb_en_r  <= ex_rw;
        rwb_a_r   <= ex_rwa;
        rwb_d_r   <= ex_rwd;
        wb_dp_r   <= ex_dp;
        wb_rp_r   <= ex_rp;
        wb_pc_r   <= ex_pc;
        wb_slot_r <= ex_abandon ? 2'd3 : slot_r + 2'd1;
        wb_halt_r <= ex_halt;
        wb_ov_r   <= ex_ov;
        wb_oc_r   <= ex_oc;
      end
      dsf_pkg::UOP_W1: begin
        res_ov_r <= wb_ov_r;
        res_oc_r <= wb_oc_r;
      end
      dsf_pkg::UOP_T1: begin
        out_r.out_valid <= res_ov_r;
        out_r.out_char  <= res_oc_r;
        out_r.halted    <= halt_r;
        out_r.top_value <= ds_rd0_r;
        out_r.read_byte <= res_rb_r;
        out_r.pc_value  <= pc_r;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/dual_stack_forth_cpu_core_unit.sv
// top level of the dual-stack processor core: sequencer plus datapath
`timescale 1ns / 1ps

// Usage:
// in_valid/in_stall/in_data carry one command word (write byte, step, read byte).
// A word is taken when in_valid is high and in_stall low; in_stall stays high
// while the previous word is in progress, so one word is worked at a time.
// Every word gives exactly one result word on out_valid/out_stall/out_data.
// A step with DIV runs 16 divider iterations.
// The rate is set by the single byte memory port and the radix-2 divider.
// A finished result sits in the output register; the next word is accepted
// while it waits, but that word's result holds until out_stall drops.
// Reset (rst_n low, synchronous) clears pc, stack pointers, slot state, halt
// and the stack valid bits; byte memory is not cleared.
module dual_stack_forth_cpu_core_unit #(
  parameter int MEM_BYTES   = 65536,
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dsf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dsf_pkg::out_word_t out_data
);

  dsf_pkg::ctl_cmd_t cmd;
  dsf_pkg::dp_stat_t stat;
  logic              busy;

  assign in_stall = busy;

  dsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .busy     (busy),
    .stat     (stat),
    .cmd      (cmd)
  );

  dsf_dpath #(
    .MEM_BYTES   (MEM_BYTES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted word did not block the input");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |=> stat.halted)
    else $error("halt flag cleared without reset");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.uop == dsf_pkg::UOP_T1 |-> !out_valid || !out_stall)
    else $error("result register overwritten while stalled");

endmodule

>>> tb/tb.sv
// self-checking bench for the dual-stack processor core: program and step stimulus
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_WORDS = 520;
  localparam int QUIET_FROM = 470;

  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam int KIND_DATA = 0;
  localparam int KIND_LO   = 1;
  localparam int KIND_HI   = 2;

  typedef struct {
    dsf_pkg::in_word_t  w;
    bit                 typed;
    dsf_pkg::out_word_t want;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  dsf_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  dsf_pkg::out_word_t out_data;

  dual_stack_forth_cpu_core_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // core state as seen by the bench
  logic [15:0] dstk [16];
  logic [15:0] rstk [16];
  logic [3:0]  dp, rp;
  logic [15:0] pc, pend;
  int          slot;
  bit          halt;
  logic [7:0]  mem [bit [15:0]];
  bit [15:0]   written [$];

  // trial execution to find bytes a step would read before they are written
  bit          trial;
  logic [7:0]  scratch [bit [15:0]];
  int          miss_addr;
  int          miss_kind;

  dsf_pkg::out_word_t want_q [$];
  row_t        plan [$];
  int          errors;
  int          idle_cycles;
  int          stall_left;
  bit          quiet;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] mem_get(logic [15:0] a, int kind);
    if (trial && scratch.exists(a)) return scratch[a];
    if (mem.exists(a)) return mem[a];
    if (trial && miss_addr < 0) begin
      miss_addr = int'(a);
      miss_kind = kind;
    end
    return 8'h00;
  endfunction

  function automatic void mem_put(logic [15:0] a, logic [7:0] v);
    if (trial) begin
      scratch[a] = v;
    end else begin
      mem[a] = v;
      written.push_back(a);
    end
  endfunction

  function automatic logic [15:0] sext(logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  function automatic void push_d(logic [15:0] v);
    dp = dp + 4'd1;
    dstk[dp] = v;
  endfunction

  function automatic logic [15:0] next_word(int k0, int k1);
    logic [7:0] lo, hi;
    lo = mem_get(pc, k0);
    hi = mem_get(pc + 16'd1, k1);
    pc = pc + 16'd2;
    return {hi, lo};
  endfunction

  // returns 1 when the rest of the word is abandoned
  function automatic bit run_slot(logic [4:0] op, logic [7:0] ch,
                                  inout dsf_pkg::out_word_t o);
    logic [15:0] x, y, t;
    logic [31:0] r;
    x = dstk[dp];
    y = dstk[dp - 4'd1];
    r = '0;
    if (op >= dsf_pkg::OP_ADD && op <= dsf_pkg::OP_SHR) begin
      case (op)
        dsf_pkg::OP_ADD: r = y + x;
        dsf_pkg::OP_SUB: r = y - x;
        dsf_pkg::OP_MUL: r = y * x;
        dsf_pkg::OP_DIV: r = (x != 0) ? y / x : 32'hFFFF;
        dsf_pkg::OP_AND: r = y & x;
        dsf_pkg::OP_OR:  r = y | x;
        dsf_pkg::OP_XOR: r = y ^ x;
        dsf_pkg::OP_SHL: r = (x < 16) ? ({16'h0, y} << x[3:0]) : 0;
        dsf_pkg::OP_SHR: r = (x < 16) ? ({16'h0, y} >> x[3:0]) : 0;
        default: r = '0;
      endcase
      if (op == dsf_pkg::OP_NOT) begin
        dstk[dp] = ~x;
      end else begin
        dstk[dp - 4'd1] = r[15:0];
        dstk[dp] = 16'h0;
        dp = dp - 4'd1;
      end
      return 0;
    end
    case (op)
      dsf_pkg::OP_HALT: begin
        halt = 1;
        return 1;
      end
      dsf_pkg::OP_IN: push_d({8'h00, ch});
      dsf_pkg::OP_OUT: begin
        o.out_valid = 1'b1;
        o.out_char = x[7:0];
        dp = dp - 4'd1;
      end
      dsf_pkg::OP_READ, dsf_pkg::OP_WRITE: dp = dp - 4'd3;
      dsf_pkg::OP_LD16: begin
        t = {mem_get(x + 16'd1, KIND_DATA), mem_get(x, KIND_DATA)};
        push_d(t);
        dstk[dp - 4'd1] = x + 16'd2;
      end
      dsf_pkg::OP_LD8: begin
        push_d({8'h00, mem_get(x, KIND_DATA)});
        dstk[dp - 4'd1] = x + 16'd1;
      end
      dsf_pkg::OP_ST16: begin
        mem_put(y, x[7:0]);
        mem_put(y + 16'd1, x[15:8]);
        dstk[dp - 4'd1] = y + 16'd2;
        dp = dp - 4'd1;
      end
      dsf_pkg::OP_ST8: begin
        mem_put(y, x[7:0]);
        dstk[dp - 4'd1] = y + 16'd1;
        dp = dp - 4'd1;
      end
      dsf_pkg::OP_LIT16: begin
        t = next_word(KIND_DATA, KIND_DATA);
        push_d(t);
      end
      dsf_pkg::OP_LIT8: begin
        t = sext(mem_get(pc, KIND_DATA));
        pc = pc + 16'd1;
        push_d(t);
      end
      dsf_pkg::OP_ZJUMP: begin
        dp = dp - 4'd1;
        if (x == 0) begin
          pc = pc + sext(mem_get(pc, KIND_DATA));
          return 1;
        end
        pc = pc + 16'd1;
      end
      dsf_pkg::OP_NEXT: begin
        if (rstk[rp] > 0) begin
          rstk[rp] = rstk[rp] - 16'd1;
          pc = pc - {8'h00, mem_get(pc, KIND_DATA)};
          return 1;
        end
        rp = rp - 4'd1;
        pc = pc + 16'd1;
      end
      dsf_pkg::OP_DROP: dp = dp - 4'd1;
      dsf_pkg::OP_DUP:  push_d(x);
      dsf_pkg::OP_OVER: push_d(y);
      dsf_pkg::OP_SWAP: begin
        dstk[dp] = y;
        dstk[dp - 4'd1] = x;
      end
      dsf_pkg::OP_PUSH: begin
        rp = rp + 4'd1;
        rstk[rp] = x;
        dp = dp - 4'd1;
      end
      dsf_pkg::OP_POP: begin
        push_d(rstk[rp]);
        rp = rp - 4'd1;
      end
      dsf_pkg::OP_PEEK: push_d(rstk[rp]);
      dsf_pkg::OP_RET: begin
        pc = rstk[rp];
        rp = rp - 4'd1;
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic dsf_pkg::out_word_t core_model(dsf_pkg::in_word_t w);
    dsf_pkg::out_word_t o;
    logic [15:0] cw;
    logic [4:0]  op;
    o = '0;
    case (w.cmd)
      dsf_pkg::CMD_WRITE: mem_put(w.mem_addr, w.mem_byte);
      dsf_pkg::CMD_READ:  o.read_byte = mem_get(w.mem_addr, KIND_DATA);
      dsf_pkg::CMD_STEP: begin
        if (!halt) begin
          if (slot >= 3) begin
            cw = next_word(KIND_LO, KIND_HI);
            if (!cw[0]) begin
              rp = rp + 4'd1;
              rstk[rp] = pc;
              pc = cw;
            end else begin
              pend = cw;
              slot = 0;
            end
          end
          if (slot < 3 && !(pend == 16'h0)) begin
            op = 5'(pend >> (11 - 5 * slot));
            if (run_slot(op, w.in_char, o)) slot = 3;
            else slot = slot + 1;
          end
        end
      end
      default: ;
    endcase
    o.halted = halt;
    o.top_value = dstk[dp];
    o.pc_value = pc;
    return o;
  endfunction

  task automatic drive_word(dsf_pkg::in_word_t w);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send(dsf_pkg::in_word_t w);
    want_q.push_back(core_model(w));
    drive_word(w);
  endtask

  function automatic logic [7:0] nz_bits(int n);
    return 8'($urandom_range(1, (1 << n) - 1));
  endfunction

  // writes every unwritten byte a step would read, shaped as code where fetched
  task automatic step_word(dsf_pkg::in_word_t w);
    logic [15:0] s_dstk [16];
    logic [15:0] s_rstk [16];
    logic [3:0]  s_dp, s_rp;
    logic [15:0] s_pc, s_pend;
    int          s_slot;
    bit          s_halt;
    dsf_pkg::out_word_t junk;
    dsf_pkg::in_word_t  fill;
    forever begin
      s_dstk = dstk; s_rstk = rstk; s_dp = dp; s_rp = rp;
      s_pc = pc; s_pend = pend; s_slot = slot; s_halt = halt;
      trial = 1;
      scratch.delete();
      miss_addr = -1;
      junk = core_model(w);
      trial = 0;
      dstk = s_dstk; rstk = s_rstk; dp = s_dp; rp = s_rp;
      pc = s_pc; pend = s_pend; slot = s_slot; halt = s_halt;
      if (miss_addr < 0) break;
      fill = '0;
      fill.cmd = dsf_pkg::CMD_WRITE;
      fill.mem_addr = 16'(miss_addr);
      fill.in_char = 8'($urandom_range(0, 255));
      if (miss_kind == KIND_LO)
        fill.mem_byte = {2'($urandom_range(0, 3)), 5'(nz_bits(5)),
                         1'($urandom_range(0, 3) != 0)};
      else if (miss_kind == KIND_HI)
        fill.mem_byte = {5'(nz_bits(5)), 3'(nz_bits(3))};
      else
        fill.mem_byte = 8'($urandom_range(0, 255));
      send(fill);
    end
    send(w);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [15:0] slots(logic [4:0] a, logic [4:0] b, logic [4:0] c);
    return {a, b, c, 1'b1};
  endfunction

  function automatic void add(logic [1:0] c, logic [15:0] a, logic [7:0] b,
                              logic [7:0] ch, bit typed, dsf_pkg::out_word_t want);
    row_t r;
    r.w = '{cmd: c, mem_addr: a, mem_byte: b, in_char: ch};
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        report("unexpected word", out_data, 0);
      end else begin
        if (out_data.out_valid !== want_q[0].out_valid)
          report("out_valid", out_data.out_valid, want_q[0].out_valid);
        if (out_data.out_char !== want_q[0].out_char)
          report("out_char", out_data.out_char, want_q[0].out_char);
        if (out_data.halted !== want_q[0].halted)
          report("halted", out_data.halted, want_q[0].halted);
        if (out_data.top_value !== want_q[0].top_value)
          report("top_value", out_data.top_value, want_q[0].top_value);
        if (out_data.read_byte !== want_q[0].read_byte)
          report("read_byte", out_data.read_byte, want_q[0].read_byte);
        if (out_data.pc_value !== want_q[0].pc_value)
          report("pc_value", out_data.pc_value, want_q[0].pc_value);
        void'(want_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dsf_pkg::in_word_t  w;
    dsf_pkg::out_word_t z;
    dsf_pkg::out_word_t rd_ff;
    logic [15:0] hw;
    int k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    errors = 0;
    quiet = 0;
    trial = 0;
    for (k = 0; k < 16; k++) begin
      dstk[k] = '0;
      rstk[k] = '0;
    end
    dp = 4'hF; rp = 4'hF; pc = '0; pend = '0; slot = 3; halt = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z = '0;
    rd_ff = '0;
    rd_ff.read_byte = 8'hFF;
    add(CMD_NONE, 16'hFFFF, 8'hFF, 8'hFF, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'hFFFF, 8'hFF, 8'h00, 1, z);
    add(dsf_pkg::CMD_READ, 16'hFFFF, 8'h00, 8'h00, 1, rd_ff);
    hw = slots(dsf_pkg::OP_LIT8, dsf_pkg::OP_LIT8, dsf_pkg::OP_DIV);
    add(dsf_pkg::CMD_WRITE, 16'd0, hw[7:0], 8'h00, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'd1, hw[15:8], 8'h00, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'd2, 8'h85, 8'h00, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'd3, 8'h00, 8'h00, 1, z);
    hw = slots(dsf_pkg::OP_LIT16, dsf_pkg::OP_SHL, dsf_pkg::OP_NOT);
    add(dsf_pkg::CMD_WRITE, 16'd4, hw[7:0], 8'h00, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'd5, hw[15:8], 8'h00, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'd6, 8'h10, 8'h00, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'd7, 8'h00, 8'h00, 1, z);
    hw = slots(dsf_pkg::OP_IN, dsf_pkg::OP_OUT, dsf_pkg::OP_NOP);
    add(dsf_pkg::CMD_WRITE, 16'd8, hw[7:0], 8'h00, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'd9, hw[15:8], 8'h00, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'd10, 8'h0C, 8'h00, 1, z);
    add(dsf_pkg::CMD_WRITE, 16'd11, 8'h00, 8'h00, 1, z);
    for (k = 0; k < 10; k++) add(dsf_pkg::CMD_STEP, 16'h0000, 8'h00, 8'hFF, 0, z);

    foreach (plan[i]) begin
      if (plan[i].w.cmd == dsf_pkg::CMD_STEP) begin
        step_word(plan[i].w);
      end else if (plan[i].typed) begin
        void'(core_model(plan[i].w));
        want_q.push_back(plan[i].want);
        drive_word(plan[i].w);
      end else begin
        send(plan[i].w);
      end
    end

    for (int i = 0; i < RAND_WORDS; i++) begin
      quiet = (i >= QUIET_FROM);
      w.mem_addr = 16'($urandom_range(0, 65535));
      w.mem_byte = 8'($urandom_range(0, 255));
      w.in_char = 8'($urandom_range(0, 255));
      k = $urandom_range(0, 99);
      if (k < 70) begin
        w.cmd = dsf_pkg::CMD_STEP;
        step_word(w);
      end else if (k < 84) begin
        w.cmd = dsf_pkg::CMD_WRITE;
        send(w);
      end else if (k < 96) begin
        w.cmd = dsf_pkg::CMD_READ;
        w.mem_addr = written[$urandom_range(0, written.size() - 1)];
        send(w);
      end else begin
        w.cmd = CMD_NONE;
        send(w);
      end
    end

    // finish on a deliberate halt
    w = '0;
    w.cmd = dsf_pkg::CMD_STEP;
    while (!halt && slot < 3) step_word(w);
    if (!halt) begin
      hw = slots(dsf_pkg::OP_HALT, dsf_pkg::OP_NOP, dsf_pkg::OP_NOP);
      send('{cmd: dsf_pkg::CMD_WRITE, mem_addr: pc, mem_byte: hw[7:0], in_char: 8'h00});
      send('{cmd: dsf_pkg::CMD_WRITE, mem_addr: pc + 16'd1, mem_byte: hw[15:8],
             in_char: 8'h00});
    end
    step_word(w);
    step_word(w);
    send('{cmd: dsf_pkg::CMD_READ, mem_addr: 16'hFFFF, mem_byte: 8'h00, in_char: 8'h00});

    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
